/* sv/hvn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg: shared constants for the hashed value noise pipeline
// Widths, hash constants and pipeline geometry for the stage modules.
// ----------------------------------------------------------------------------
package hvn_pkg;

  // Noise resolution of the corner values and of the interpolated result.
  localparam int NOISE_BITS = 8;
  localparam int OUT_W      = 8;

  // Coordinate and cell geometry.
  localparam int COORD_W   = 32;
  localparam int SH_W      = 3;
  localparam int MAX_SHIFT = 6;
  localparam int OFS_W     = MAX_SHIFT;
  localparam int SIZE_W    = MAX_SHIFT + 1;
  localparam int SQ_W      = 2 * OFS_W;
  localparam int TRI_W     = SIZE_W + 2;
  localparam int PROD_W    = SQ_W + TRI_W;
  localparam int LERP_W    = NOISE_BITS + SIZE_W;

  // Lattice hash constants.
  localparam logic [31:0] HASH_C0   = 32'h9e37_79b9;
  localparam logic [31:0] HASH_K1   = 32'h85eb_ca6b;
  localparam logic [31:0] HASH_K2   = 32'hc2b2_ae35;
  localparam logic [31:0] HASH_K3   = 32'h27d4_eb2f;
  localparam logic [31:0] HASH_SALT = 32'h51ed_270b;
  localparam int          HASH_SH1  = 13;
  localparam int          HASH_SH2  = 16;
  localparam int          HASH_SH3  = 15;

  // Pipeline depth in register stages, input split to output register.
  localparam int STAGES = 7;

  // Configuration space.
  localparam int          DATA_W   = 32;
  localparam int          ADDR_W   = 3;
  localparam logic [0:0]  REG_SEED = 1'b0;

endpackage

/* sv/hvn_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_split: lattice split stage
// Clamps the cell shift and splits each coordinate into a cell corner, the
// next corner and an in-cell offset.
// ----------------------------------------------------------------------------
module hvn_split import hvn_pkg::*; (
  input  logic                      clk,
  input  logic                      stage_en,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic [SH_W-1:0]           cell_shift,
  output logic [COORD_W-1:0]        cx_r,
  output logic [COORD_W-1:0]        cx1_r,
  output logic [COORD_W-1:0]        cy_r,
  output logic [COORD_W-1:0]        cy1_r,
  output logic [OFS_W-1:0]          ox_r,
  output logic [OFS_W-1:0]          oy_r,
  output logic [SH_W-1:0]           sh_r
);

  logic [SH_W-1:0]    sh_nxt;
  logic [SIZE_W-1:0]  size;
  logic [OFS_W-1:0]   ofs_mask;
  logic [COORD_W-1:0] cx_nxt;
  logic [COORD_W-1:0] cy_nxt;

  // Shift codes above the maximum saturate; floor division is an arithmetic shift.
  always_comb begin
    sh_nxt   = (cell_shift > SH_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : cell_shift;
    size     = SIZE_W'(1) << sh_nxt;
    ofs_mask = OFS_W'(size - SIZE_W'(1));
    cx_nxt   = COORD_W'(x_coord >>> sh_nxt);
    cy_nxt   = COORD_W'(y_coord >>> sh_nxt);
  end

  // The neighbor corner wraps in two's complement.
  always_ff @(posedge clk) begin
    if (stage_en) begin
      cx_r  <= cx_nxt;
      cx1_r <= cx_nxt + COORD_W'(1);
      cy_r  <= cy_nxt;
      cy1_r <= cy_nxt + COORD_W'(1);
      ox_r  <= x_coord[OFS_W-1:0] & ofs_mask;
      oy_r  <= y_coord[OFS_W-1:0] & ofs_mask;
      sh_r  <= sh_nxt;
    end
  end

endmodule

/* sv/hvn_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_hash: four-lane lattice hash
// Multiply-xorshift hash of seed, corner and salt, one multiply per stage.
// The x round is shared between the two corners of each column.
// ----------------------------------------------------------------------------
module hvn_hash import hvn_pkg::*; (
  input  logic                                clk,
  input  logic [3:0]                          stage_en,
  input  logic [31:0]                         seed,
  input  logic [COORD_W-1:0]                  cx,
  input  logic [COORD_W-1:0]                  cx1,
  input  logic [COORD_W-1:0]                  cy,
  input  logic [COORD_W-1:0]                  cy1,
  output logic [3:0][NOISE_BITS-1:0]          corner_r
);

  logic [1:0][31:0] m1_r;
  logic [31:0]      cy_d_r;
  logic [31:0]      cy1_d_r;
  logic [1:0][31:0] h1;
  logic [3:0][31:0] m2_r;
  logic [3:0][31:0] h2;
  logic [3:0][31:0] m3_r;
  logic [3:0][31:0] h3;
  logic [1:0][31:0] xin;

  // First round: one multiply per x corner.
  always_comb begin
    xin[0] = seed ^ HASH_C0 ^ cx;
    xin[1] = seed ^ HASH_C0 ^ cx1;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      m1_r[0] <= xin[0] * HASH_K1;
      m1_r[1] <= xin[1] * HASH_K1;
      cy_d_r  <= cy;
      cy1_d_r <= cy1;
    end
  end

  // Second round: lane bit 0 picks the x corner, lane bit 1 the y corner.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      h1[i] = m1_r[i] ^ (m1_r[i] >> HASH_SH1);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      m2_r[0] <= (h1[0] ^ cy_d_r) * HASH_K2;
      m2_r[1] <= (h1[1] ^ cy_d_r) * HASH_K2;
      m2_r[2] <= (h1[0] ^ cy1_d_r) * HASH_K2;
      m2_r[3] <= (h1[1] ^ cy1_d_r) * HASH_K2;
    end
  end

  // Third round mixes in the salt, then the final xorshift and mask.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h2[i] = m2_r[i] ^ (m2_r[i] >> HASH_SH2);
      h3[i] = m3_r[i] ^ (m3_r[i] >> HASH_SH3);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      for (int i = 0; i < 4; i++) begin
        m3_r[i] <= (h2[i] ^ HASH_SALT) * HASH_K3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      for (int i = 0; i < 4; i++) begin
        corner_r[i] <= h3[i][NOISE_BITS-1:0];
      end
    end
  end

endmodule

/* sv/hvn_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_weight: smoothstep weights
// Integer smoothstep o^2 * (3*size - 2*o) / size^2 for both axes,
// over three stages: square, product, normalizing shift.
// ----------------------------------------------------------------------------
module hvn_weight import hvn_pkg::*; (
  input  logic                        clk,
  input  logic [2:0]                  stage_en,
  input  logic [1:0][OFS_W-1:0]       ofs,
  input  logic [SH_W-1:0]             sh,
  output logic [1:0][SIZE_W-1:0]      w_r,
  output logic [SH_W-1:0]             sh_out_r
);

  logic [1:0][SQ_W-1:0]   sq_r;
  logic [1:0][OFS_W-1:0]  ofs1_r;
  logic [SH_W-1:0]        sh1_r;
  logic [1:0][PROD_W-1:0] prod_r;
  logic [SH_W-1:0]        sh2_r;
  logic [TRI_W-1:0]       size3;
  logic [1:0][TRI_W-1:0]  tri_w;
  logic [1:0][PROD_W-1:0] scaled;

  // Square of the offset.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int a = 0; a < 2; a++) begin
        sq_r[a]   <= SQ_W'(ofs[a]) * SQ_W'(ofs[a]);
        ofs1_r[a] <= ofs[a];
      end
      sh1_r <= sh;
    end
  end

  // Cubic term: square times (3*size - 2*o), always positive since o < size.
  always_comb begin
    size3 = TRI_W'(3) * (TRI_W'(1) << sh1_r);
    for (int a = 0; a < 2; a++) begin
      tri_w[a] = size3 - (TRI_W'(ofs1_r[a]) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      for (int a = 0; a < 2; a++) begin
        prod_r[a] <= PROD_W'(sq_r[a]) * PROD_W'(tri_w[a]);
      end
      sh2_r <= sh1_r;
    end
  end

  // Divide by size squared; the weight never exceeds the cell size.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      scaled[a] = prod_r[a] >> {sh2_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      for (int a = 0; a < 2; a++) begin
        w_r[a] <= scaled[a][SIZE_W-1:0];
      end
      sh_out_r <= sh2_r;
    end
  end

endmodule

/* sv/hvn_lerp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_lerp: bilinear interpolation
// Aligns the weights with the corner values, blends along x into a top and
// a bottom row, then blends the rows along y into the output register.
// ----------------------------------------------------------------------------
module hvn_lerp import hvn_pkg::*; (
  input  logic                        clk,
  input  logic [2:0]                  stage_en,
  input  logic [3:0][NOISE_BITS-1:0]  corner,
  input  logic [1:0][SIZE_W-1:0]      w,
  input  logic [SH_W-1:0]             sh,
  output logic [OUT_W-1:0]            noise_r
);

  logic [SIZE_W-1:0]     wx4_r;
  logic [SIZE_W-1:0]     wy4_r;
  logic [SH_W-1:0]       sh4_r;
  logic [SIZE_W-1:0]     size4;
  logic [SIZE_W-1:0]     wxc;
  logic [LERP_W-1:0]     top_sum;
  logic [LERP_W-1:0]     bot_sum;
  logic [NOISE_BITS-1:0] top_r;
  logic [NOISE_BITS-1:0] bot_r;
  logic [SIZE_W-1:0]     wy5_r;
  logic [SH_W-1:0]       sh5_r;
  logic [SIZE_W-1:0]     size5;
  logic [SIZE_W-1:0]     wyc;
  logic [LERP_W-1:0]     v_sum;
  logic [NOISE_BITS-1:0] v;
  logic [31:0]           v_ext;

  // Delay the weights by one stage to line up with the corner values.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      wx4_r <= w[0];
      wy4_r <= w[1];
      sh4_r <= sh;
    end
  end

  // Blend along x. Weights sum to the cell size, so the shifted sum fits.
  always_comb begin
    size4   = SIZE_W'(1) << sh4_r;
    wxc     = size4 - wx4_r;
    top_sum = (LERP_W'(corner[0]) * LERP_W'(wxc)) + (LERP_W'(corner[1]) * LERP_W'(wx4_r));
    bot_sum = (LERP_W'(corner[2]) * LERP_W'(wxc)) + (LERP_W'(corner[3]) * LERP_W'(wx4_r));
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      top_r <= NOISE_BITS'(top_sum >> sh4_r);
      bot_r <= NOISE_BITS'(bot_sum >> sh4_r);
      wy5_r <= wy4_r;
      sh5_r <= sh4_r;
    end
  end

  // Blend along y and keep the low output bits.
  always_comb begin
    size5 = SIZE_W'(1) << sh5_r;
    wyc   = size5 - wy5_r;
    v_sum = (LERP_W'(top_r) * LERP_W'(wyc)) + (LERP_W'(bot_r) * LERP_W'(wy5_r));
    v     = NOISE_BITS'(v_sum >> sh5_r);
    v_ext = 32'(v);
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      noise_r <= v_ext[OUT_W-1:0];
    end
  end

endmodule

/* sv/hashed_value_noise_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_value_noise_2d: pipelined 2D value noise
// Usage:
//   The input channel (in_valid/in_ready) takes one sample coordinate pair
//   and a cell shift per transfer. The output channel (out_valid/out_ready)
//   returns one noise value per sample, in order.
//   The seed register sits at byte address 0 of the APB port; write it only
//   while no sample is in flight. pready is tied high.
//   The pipeline has seven register stages: split, hash rounds on 32x32
//   multipliers (one per x corner in the first round, one per lane after),
//   corner mask, x blend and y blend into the output register. Throughput
//   is one sample per cycle while the receiver does not stall.
//   Each stage has a valid bit; a stage loads when it is empty or the next
//   stage moves, so bubbles close up. When the receiver stalls, the held
//   result stays on the output and in_ready stays high until every stage
//   is full; nothing is dropped or repeated.
//   Reset clears all valid bits and sets the seed to zero.
// ----------------------------------------------------------------------------
module hashed_value_noise_2d import hvn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic [SH_W-1:0]           in_cell_shift,
  // Output channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_W-1:0]          out_noise_value,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  logic [31:0]                seed_r;
  logic [31:0]                seed_nxt;
  logic                       reg_idx;
  logic [STAGES-1:0]          vld_r;
  logic [STAGES-1:0]          vld_nxt;
  logic [STAGES-1:0]          stage_en;
  logic [STAGES-1:0]          vld_prev;

  logic [COORD_W-1:0]         cx;
  logic [COORD_W-1:0]         cx1;
  logic [COORD_W-1:0]         cy;
  logic [COORD_W-1:0]         cy1;
  logic [1:0][OFS_W-1:0]      ofs;
  logic [SH_W-1:0]            sh0;
  logic [1:0][SIZE_W-1:0]     w;
  logic [SH_W-1:0]            sh3;
  logic [3:0][NOISE_BITS-1:0] corner;

  // Register access: the word index is the address above the byte bits.
  assign reg_idx = paddr[ADDR_W-1];
  assign pready  = 1'b1;

  always_comb begin
    seed_nxt = seed_r;
    if (psel && penable && pwrite && pready && (reg_idx == REG_SEED)) begin
      seed_nxt = pwdata;
    end
    prdata = (reg_idx == REG_SEED) ? seed_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves.
  always_comb begin
    stage_en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    vld_prev = {vld_r[STAGES-2:0], in_valid};
    for (int k = 0; k < STAGES; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_prev[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = vld_r[STAGES-1];

  // Stage 0: lattice split.
  hvn_split u_split (
    .clk        (clk),
    .stage_en   (stage_en[0]),
    .x_coord    (in_x_coord),
    .y_coord    (in_y_coord),
    .cell_shift (in_cell_shift),
    .cx_r       (cx),
    .cx1_r      (cx1),
    .cy_r       (cy),
    .cy1_r      (cy1),
    .ox_r       (ofs[0]),
    .oy_r       (ofs[1]),
    .sh_r       (sh0)
  );

  // Stages 1 to 4: corner hashes.
  hvn_hash u_hash (
    .clk      (clk),
    .stage_en (stage_en[4:1]),
    .seed     (seed_r),
    .cx       (cx),
    .cx1      (cx1),
    .cy       (cy),
    .cy1      (cy1),
    .corner_r (corner)
  );

  // Stages 1 to 3: smoothstep weights.
  hvn_weight u_weight (
    .clk      (clk),
    .stage_en (stage_en[3:1]),
    .ofs      (ofs),
    .sh       (sh0),
    .w_r      (w),
    .sh_out_r (sh3)
  );

  // Stages 4 to 6: interpolation and output register.
  hvn_lerp u_lerp (
    .clk      (clk),
    .stage_en (stage_en[6:4]),
    .corner   (corner),
    .w        (w),
    .sh       (sh3),
    .noise_r  (out_noise_value)
  );

endmodule
